### hw/rtl/shr_pkg.sv
package shr_pkg;

    localparam int DEPTH     = 32768;
    localparam int WORD_BITS = 32;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int LEN_W     = PTR_W + 1;
    localparam int FRAME_W   = 13;
    localparam int HIST_W    = 6;
    localparam int ACT_W     = 2;
    localparam int POS_W     = 15;
    localparam int BACK_W    = 5;
    localparam int STAT_W    = 2;
    localparam int PROD_W    = BACK_W + FRAME_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MOD_STEPS = PROD_W;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam int IN_TDATA_RAW  = WORD_BITS + 1 + POS_W + BACK_W;
    localparam int IN_TDATA_W    = ((IN_TDATA_RAW + 7) / 8) * 8;
    localparam int IN_TUSER_W    = ACT_W;
    localparam int OUT_TDATA_RAW = WORD_BITS + POS_W;
    localparam int OUT_TDATA_W   = ((OUT_TDATA_RAW + 7) / 8) * 8;
    localparam int OUT_TUSER_W   = 1 + STAT_W;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [PTR_W-1:0]     ptr_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [PROD_W-1:0]    prod_t;

    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LATEST = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PAST   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PAST_END = 2'd2;
    localparam logic [STAT_W-1:0] STAT_LOOKBACK = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WORDS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WORDS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_FRAMES = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_BUFFER_WORDS   = 16'd17100;
    localparam logic [FRAME_W-1:0]    RST_FRAME_WORDS    = 13'd684;
    localparam logic [HIST_W-1:0]     RST_HISTORY_FRAMES = 6'd25;

    // The ring length is the programmed value held to the range [2, DEPTH].
    function automatic len_t ring_len(input logic [CFG_DATA_W-1:0] bw);
        if (bw < CFG_DATA_W'(2)) begin
            return LEN_W'(2);
        end else if (32'(bw) > 32'(DEPTH)) begin
            return LEN_W'(DEPTH);
        end else begin
            return LEN_W'(bw);
        end
    endfunction

endpackage

### hw/rtl/shr_ram.sv
module shr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/shr_mod.sv
module shr_mod (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  shr_pkg::prod_t dividend,
    input  shr_pkg::len_t  divisor,
    output logic           done,
    output shr_pkg::len_t  rem
);
    import shr_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    prod_t                dvd_reg, dvd_next;
    len_t                 rem_reg, rem_next;
    logic [LEN_W:0]       trial;

    // One restoring step per cycle, most significant dividend bit first.
    always_comb begin
        trial     = {rem_reg, dvd_reg[PROD_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = MOD_CNT_W'(MOD_STEPS - 1);
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = LEN_W'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[LEN_W-1:0];
            end
            dvd_next = {dvd_reg[PROD_W-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - MOD_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### hw/rtl/scan_history_ring_buffer.sv
// Circular store of 32-bit scan words with frame lookback. One request is
// taken at a time and answered by exactly one result; a new request is
// accepted as soon as the previous one has moved into the output register.
// Writes, clears and rejected reads go from acceptance through the execute
// state to the output state; a latest-run read also passes through the read
// state, as the word memory read is registered. A past-frame read first has
// the frame step and the final index each reduced modulo the ring length by an
// 18-step remainder unit, one bit per cycle. The word memory needs no clearing pass
// after reset, and words that were never written read back as arbitrary data.
// Writing buffer_words resets both pointers and the current write run.
module scan_history_ring_buffer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata: value[31:0], first[32], position[47:33], frames_back[52:48]
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [shr_pkg::IN_TDATA_W-1:0]        s_tdata,
    // s_tuser: action[1:0]
    input  logic [shr_pkg::IN_TUSER_W-1:0]        s_tuser,
    // m_tdata: word_out[31:0], readable_count[46:32]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [shr_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // m_tuser: valid_res[0], status[2:1]
    output logic [shr_pkg::OUT_TUSER_W-1:0]       m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [shr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [shr_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import shr_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_MOD_BACK = 3'd2;
    localparam logic [2:0] S_MOD_IDX  = 3'd3;
    localparam logic [2:0] S_READ     = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;

    logic [2:0]              state_reg, state_next;
    ptr_t                    wp_reg, wp_next;
    ptr_t                    rp_reg, rp_next;
    ptr_t                    alw_reg, alw_next;
    ptr_t                    tak_reg, tak_next;
    len_t                    len_reg, len_next;
    logic [FRAME_W-1:0]      frame_reg, frame_next;
    logic [HIST_W-1:0]       hist_reg, hist_next;

    logic [ACT_W-1:0]        act_reg, act_next;
    word_t                   val_reg, val_next;
    logic                    first_reg, first_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [BACK_W-1:0]       back_reg, back_next;

    word_t                   res_word_reg, res_word_next;
    logic                    res_valid_reg, res_valid_next;
    logic [STAT_W-1:0]       res_stat_reg, res_stat_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    ptr_t                    readable;
    ptr_t                    alw_first, alw_eff, tak_eff;
    len_t                    wp_inc;
    ptr_t                    wp_wrap;
    len_t                    lat_sum;
    ptr_t                    lat_idx;
    ptr_t                    back_steps;
    len_t                    past_start;
    prod_t                   step_prod;

    logic                    ram_we;
    ptr_t                    ram_addr;
    word_t                   ram_rdata;
    logic                    mod_start;
    prod_t                   mod_dvd;
    logic                    mod_done;
    len_t                    mod_rem;

    shr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (val_reg),
        .rdata (ram_rdata)
    );

    shr_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (mod_dvd),
        .divisor  (len_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb begin
        if (wp_reg >= rp_reg) begin
            readable = wp_reg - rp_reg;
        end else begin
            readable = PTR_W'(len_reg - LEN_W'(rp_reg - wp_reg));
        end

        alw_first = PTR_W'(len_reg - LEN_W'(readable) - LEN_W'(1));
        alw_eff   = first_reg ? alw_first : alw_reg;
        tak_eff   = first_reg ? '0 : tak_reg;

        wp_inc  = LEN_W'(wp_reg) + LEN_W'(1);
        wp_wrap = (wp_inc >= len_reg) ? '0 : wp_inc[PTR_W-1:0];

        lat_sum = LEN_W'(rp_reg) + LEN_W'(pos_reg);
        lat_idx = (lat_sum >= len_reg) ? PTR_W'(lat_sum - len_reg) : lat_sum[PTR_W-1:0];

        back_steps = mod_rem[PTR_W-1:0];
        if (rp_reg >= back_steps) begin
            past_start = LEN_W'(rp_reg - back_steps);
        end else begin
            past_start = LEN_W'(rp_reg) + len_reg - LEN_W'(back_steps);
        end

        step_prod = PROD_W'(back_reg) * PROD_W'(frame_reg);
    end

    always_comb begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        alw_next       = alw_reg;
        tak_next       = tak_reg;
        len_next       = len_reg;
        frame_next     = frame_reg;
        hist_next      = hist_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        first_next     = first_reg;
        pos_next       = pos_reg;
        back_next      = back_reg;
        res_word_next  = res_word_reg;
        res_valid_next = res_valid_reg;
        res_stat_next  = res_stat_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        ram_we         = 1'b0;
        ram_addr       = wp_reg;
        mod_start      = 1'b0;
        mod_dvd        = step_prod;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tuser[ACT_W-1:0];
                    val_next   = s_tdata[WORD_BITS-1:0];
                    first_next = s_tdata[WORD_BITS];
                    pos_next   = s_tdata[WORD_BITS+1 +: POS_W];
                    back_next  = s_tdata[WORD_BITS+1+POS_W +: BACK_W];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_word_next  = '0;
                res_valid_next = 1'b0;
                res_stat_next  = STAT_OK;
                state_next     = S_OUT;
                unique case (act_reg)
                    ACT_WRITE: begin
                        if (first_reg) begin
                            rp_next  = wp_reg;
                            alw_next = alw_first;
                            tak_next = '0;
                        end
                        if (tak_eff < alw_eff) begin
                            ram_we         = 1'b1;
                            wp_next        = wp_wrap;
                            tak_next       = tak_eff + PTR_W'(1);
                            res_word_next  = val_reg;
                            res_valid_next = 1'b1;
                        end else begin
                            res_stat_next = STAT_FULL;
                        end
                    end
                    ACT_LATEST: begin
                        if (pos_reg < readable) begin
                            ram_addr       = lat_idx;
                            res_valid_next = 1'b1;
                            state_next     = S_READ;
                        end else begin
                            res_stat_next = STAT_PAST_END;
                        end
                    end
                    ACT_PAST: begin
                        if (HIST_W'(back_reg) >= hist_reg) begin
                            res_stat_next = STAT_LOOKBACK;
                        end else begin
                            mod_start      = 1'b1;
                            res_valid_next = 1'b1;
                            state_next     = S_MOD_BACK;
                        end
                    end
                    ACT_CLEAR: begin
                        wp_next  = '0;
                        rp_next  = '0;
                        alw_next = '0;
                        tak_next = '0;
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_MOD_BACK: begin
                if (mod_done) begin
                    mod_start  = 1'b1;
                    mod_dvd    = PROD_W'(past_start) + PROD_W'(pos_reg);
                    state_next = S_MOD_IDX;
                end
            end
            S_MOD_IDX: begin
                if (mod_done) begin
                    ram_addr   = mod_rem[PTR_W-1:0];
                    state_next = S_READ;
                end
            end
            S_READ: begin
                res_word_next = ram_rdata;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({readable, res_word_reg});
                    m_tuser_next  = {res_stat_reg, res_valid_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BUFFER_WORDS: begin
                    len_next = ring_len(cfg_data);
                    wp_next  = '0;
                    rp_next  = '0;
                    alw_next = '0;
                    tak_next = '0;
                end
                REG_FRAME_WORDS: begin
                    frame_next = cfg_data[FRAME_W-1:0];
                end
                REG_HISTORY_FRAMES: begin
                    hist_next = cfg_data[HIST_W-1:0];
                end
                default: begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wp_reg       <= '0;
            rp_reg       <= '0;
            alw_reg      <= '0;
            tak_reg      <= '0;
            len_reg      <= ring_len(RST_BUFFER_WORDS);
            frame_reg    <= RST_FRAME_WORDS;
            hist_reg     <= RST_HISTORY_FRAMES;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            alw_reg      <= alw_next;
            tak_reg      <= tak_next;
            len_reg      <= len_next;
            frame_reg    <= frame_next;
            hist_reg     <= hist_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        act_reg       <= act_next;
        val_reg       <= val_next;
        first_reg     <= first_next;
        pos_reg       <= pos_next;
        back_reg      <= back_next;
        res_word_reg  <= res_word_next;
        res_valid_reg <= res_valid_next;
        res_stat_reg  <= res_stat_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule
